// ----- rtl/rwcp_pkg.sv -----
// ----------------------------------------------------------------------------
// rwcp_pkg
// Types, chunk identifiers and helpers shared by the RIFF WAVE chunk parser.
// ----------------------------------------------------------------------------
package rwcp_pkg;

  // Chunk and form identifiers as little-endian 32-bit words
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] ID_LIST = 32'h5453_494C;
  localparam logic [31:0] ID_INFO = 32'h4F46_4E49;
  localparam logic [31:0] ID_IART = 32'h5452_4149;
  localparam logic [31:0] ID_ICOP = 32'h504F_4349;
  localparam logic [31:0] ID_ICRD = 32'h4452_4349;
  localparam logic [31:0] ID_INAM = 32'h4D41_4E49;

  localparam logic [15:0] FMT_CODE_PCM = 16'd1;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [31:0] LIST_TYPE_SIZE = 32'd4;

  // Result queue depth; must hold the two results one byte can cause
  localparam int unsigned RWCP_RES_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_FORMAT    = 3'd1,
    KIND_INFO      = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_NOT_RIFF  = 3'd4,
    KIND_NOT_WAVE  = 3'd5,
    KIND_NOT_PCM   = 3'd6,
    KIND_SHORT_FMT = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    TAG_ARTIST    = 3'd0,
    TAG_COPYRIGHT = 3'd1,
    TAG_DATE      = 3'd2,
    TAG_NAME      = 3'd3,
    TAG_NONE      = 3'd4
  } tag_e;

  typedef enum logic [8:0] {
    PH_RIFF  = 9'b0_0000_0001,
    PH_CHDR  = 9'b0_0000_0010,
    PH_FMT   = 9'b0_0000_0100,
    PH_DATA  = 9'b0_0000_1000,
    PH_SKIP  = 9'b0_0001_0000,
    PH_LTYP  = 9'b0_0010_0000,
    PH_IHDR  = 9'b0_0100_0000,
    PH_IBODY = 9'b0_1000_0000,
    PH_HALT  = 9'b1_0000_0000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  hidx;
    logic [31:0] id_shift;
    logic [31:0] size_shift;
    logic [31:0] chunk_rem;
    logic [31:0] list_rem;
    logic [15:0] fmt_code;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    tag_e        cur_tag;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:        PH_RIFF,
    hidx:         4'd0,
    id_shift:     32'd0,
    size_shift:   32'd0,
    chunk_rem:    32'd0,
    list_rem:     32'd0,
    fmt_code:     16'd0,
    fmt_channels: 16'd0,
    fmt_rate:     32'd0,
    fmt_bits:     16'd0,
    cur_tag:      TAG_NONE
  };

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic [1:0]  info_tag;
    logic [15:0] channels;
    logic [31:0] pcm_rate;
    logic [15:0] sample_bits;
    logic        last_of_run;
  } result_t;

  // Push strobes from the parser into the result queue
  typedef struct packed {
    logic first;
    logic second;
  } res_push_t;

  function automatic logic [31:0] shift_in(logic [31:0] w, logic [7:0] b);
    return {b, w[31:8]};
  endfunction

  // Sizes with the top bit set count as zero
  function automatic logic [31:0] fix_size(logic [31:0] s);
    return s[31] ? 32'd0 : s;
  endfunction

  function automatic result_t make_result(kind_e k, logic [7:0] b, tag_e tg,
                                          logic [15:0] ch, logic [31:0] rate,
                                          logic [15:0] bits);
    result_t r;
    r             = '0;
    r.kind        = k;
    r.byte_value  = (k == KIND_PAYLOAD || k == KIND_INFO) ? b : 8'd0;
    r.info_tag    = (k == KIND_INFO) ? tg[1:0] : 2'd0;
    r.channels    = (k == KIND_FORMAT) ? ch : 16'd0;
    r.pcm_rate    = (k == KIND_FORMAT) ? rate : 32'd0;
    r.sample_bits = (k == KIND_FORMAT) ? bits : 16'd0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/rwcp_parser.sv -----
// ----------------------------------------------------------------------------
// rwcp_parser
// Input word register and the per-byte chunk walker. One registered byte is
// consumed per cycle whenever the result queue has room for two results.
// ----------------------------------------------------------------------------
module rwcp_parser import rwcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  input  logic       room_i,
  output res_push_t  push_o,
  output result_t    res0_o,
  output result_t    res1_o
);

  logic         vld_q;
  logic [7:0]   byte_q;
  logic         first_q;
  logic         last_q;
  logic         take;
  parse_state_t st_q, st_d;
  logic         r0_v, r1_v;
  result_t      r0, r1;

  assign take       = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q  <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PARSE_RESET;
    end else if (take) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    parse_state_t s;
    logic [3:0]   idx;
    logic [31:0]  size;
    s    = first_q ? PARSE_RESET : st_q;
    idx  = s.hidx;
    size = 32'd0;
    r0_v = 1'b0;
    r1_v = 1'b0;
    r0   = '0;
    r1   = '0;

    unique case (s.phase)
      PH_RIFF: begin
        if (idx >= 4'd4 && idx < 4'd8) s.size_shift = shift_in(s.size_shift, byte_q);
        else                           s.id_shift   = shift_in(s.id_shift, byte_q);
        s.hidx = idx + 4'd1;
        if (idx == 4'd3 && s.id_shift != ID_RIFF) begin
          r0_v = 1'b1;
          r0   = make_result(KIND_NOT_RIFF, 8'd0, TAG_NONE, 16'd0, 32'd0, 16'd0);
          s.phase = PH_HALT;
        end else if (idx == 4'd11) begin
          if (s.id_shift != ID_WAVE) begin
            r0_v = 1'b1;
            r0   = make_result(KIND_NOT_WAVE, 8'd0, TAG_NONE, 16'd0, 32'd0, 16'd0);
            s.phase = PH_HALT;
          end else begin
            s.phase = PH_CHDR;
            s.hidx  = 4'd0;
          end
        end else if (last_q) begin
          // image ends inside the RIFF header
          r0_v = 1'b1;
          r0   = make_result((idx < 4'd3) ? KIND_NOT_RIFF : KIND_NOT_WAVE, 8'd0,
                             TAG_NONE, 16'd0, 32'd0, 16'd0);
          s.phase = PH_HALT;
        end
      end
      PH_CHDR: begin
        if (idx < 4'd4) s.id_shift   = shift_in(s.id_shift, byte_q);
        else            s.size_shift = shift_in(s.size_shift, byte_q);
        s.hidx = idx + 4'd1;
        if (idx >= 4'd7) begin
          size   = fix_size(s.size_shift);
          s.hidx = 4'd0;
          if (s.id_shift == ID_FMT) begin
            if (size < FMT_MIN_SIZE) begin
              r0_v = 1'b1;
              r0   = make_result(KIND_SHORT_FMT, 8'd0, TAG_NONE, 16'd0, 32'd0, 16'd0);
              s.phase = PH_HALT;
            end else begin
              s.chunk_rem = size - FMT_MIN_SIZE;
              s.phase     = PH_FMT;
            end
          end else if (s.id_shift == ID_LIST) begin
            s.list_rem = (size >= LIST_TYPE_SIZE) ? size - LIST_TYPE_SIZE : 32'd0;
            s.phase    = PH_LTYP;
          end else begin
            s.chunk_rem = size;
            if (size == 32'd0)              s.phase = PH_CHDR;
            else if (s.id_shift == ID_DATA) s.phase = PH_DATA;
            else                            s.phase = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        case (idx)
          4'd0:  s.fmt_code     = {8'd0, byte_q};
          4'd1:  s.fmt_code     = s.fmt_code | {byte_q, 8'd0};
          4'd2:  s.fmt_channels = {8'd0, byte_q};
          4'd3:  s.fmt_channels = s.fmt_channels | {byte_q, 8'd0};
          4'd4:  s.fmt_rate     = {24'd0, byte_q};
          4'd5:  s.fmt_rate     = s.fmt_rate | {16'd0, byte_q, 8'd0};
          4'd6:  s.fmt_rate     = s.fmt_rate | {8'd0, byte_q, 16'd0};
          4'd7:  s.fmt_rate     = s.fmt_rate | {byte_q, 24'd0};
          4'd14: s.fmt_bits     = {8'd0, byte_q};
          4'd15: s.fmt_bits     = s.fmt_bits | {byte_q, 8'd0};
          default: ;
        endcase
        s.hidx = idx + 4'd1;
        if (idx == 4'd1 && s.fmt_code != FMT_CODE_PCM) begin
          r0_v = 1'b1;
          r0   = make_result(KIND_NOT_PCM, 8'd0, TAG_NONE, 16'd0, 32'd0, 16'd0);
          s.phase = PH_HALT;
        end else if (idx == 4'd15) begin
          r0_v = 1'b1;
          r0   = make_result(KIND_FORMAT, 8'd0, TAG_NONE, s.fmt_channels, s.fmt_rate,
                             s.fmt_bits);
          s.hidx  = 4'd0;
          s.phase = (s.chunk_rem != 32'd0) ? PH_SKIP : PH_CHDR;
        end
      end
      PH_DATA, PH_SKIP: begin
        if (s.phase == PH_DATA) begin
          r0_v = 1'b1;
          r0   = make_result(KIND_PAYLOAD, byte_q, TAG_NONE, 16'd0, 32'd0, 16'd0);
        end
        if (s.chunk_rem != 32'd0) s.chunk_rem = s.chunk_rem - 32'd1;
        if (s.chunk_rem == 32'd0) begin
          s.phase = PH_CHDR;
          s.hidx  = 4'd0;
        end
      end
      PH_LTYP: begin
        s.id_shift = shift_in(s.id_shift, byte_q);
        s.hidx     = idx + 4'd1;
        if (idx >= 4'd3) begin
          s.hidx = 4'd0;
          if (s.list_rem == 32'd0) begin
            s.phase = PH_CHDR;
          end else if (s.id_shift == ID_INFO) begin
            s.phase = PH_IHDR;
          end else begin
            s.chunk_rem = s.list_rem;
            s.phase     = PH_SKIP;
          end
        end
      end
      PH_IHDR: begin
        if (idx < 4'd4) s.id_shift   = shift_in(s.id_shift, byte_q);
        else            s.size_shift = shift_in(s.size_shift, byte_q);
        s.hidx = idx + 4'd1;
        if (s.list_rem != 32'd0) s.list_rem = s.list_rem - 32'd1;
        if (idx >= 4'd7) begin
          s.hidx = 4'd0;
          size   = fix_size(s.size_shift);
          if (s.id_shift == ID_IART)      s.cur_tag = TAG_ARTIST;
          else if (s.id_shift == ID_ICOP) s.cur_tag = TAG_COPYRIGHT;
          else if (s.id_shift == ID_ICRD) s.cur_tag = TAG_DATE;
          else if (s.id_shift == ID_INAM) s.cur_tag = TAG_NAME;
          else                            s.cur_tag = TAG_NONE;
          s.chunk_rem = size;
          s.phase     = (size != 32'd0) ? PH_IBODY : PH_IHDR;
        end
        // LIST used up: back to top-level chunk headers
        if (s.list_rem == 32'd0) begin
          s.phase = PH_CHDR;
          s.hidx  = 4'd0;
        end
      end
      PH_IBODY: begin
        if (s.cur_tag != TAG_NONE) begin
          r0_v = 1'b1;
          r0   = make_result(KIND_INFO, byte_q, s.cur_tag, 16'd0, 32'd0, 16'd0);
        end
        if (s.list_rem != 32'd0)  s.list_rem  = s.list_rem - 32'd1;
        if (s.chunk_rem != 32'd0) s.chunk_rem = s.chunk_rem - 32'd1;
        if (s.chunk_rem == 32'd0) begin
          s.phase = PH_IHDR;
          s.hidx  = 4'd0;
        end
        if (s.list_rem == 32'd0) begin
          s.phase = PH_CHDR;
          s.hidx  = 4'd0;
        end
      end
      default: ;
    endcase

    if (last_q && s.phase != PH_HALT) begin
      if (r0_v) begin
        r1_v = 1'b1;
        r1   = make_result(KIND_DONE, 8'd0, TAG_NONE, 16'd0, 32'd0, 16'd0);
      end else begin
        r0_v = 1'b1;
        r0   = make_result(KIND_DONE, 8'd0, TAG_NONE, 16'd0, 32'd0, 16'd0);
      end
      s.phase = PH_HALT;
    end
    // mark the final result of this byte
    if (r1_v)      r1.last_of_run = 1'b1;
    else if (r0_v) r0.last_of_run = 1'b1;

    st_d = s;
  end

  assign push_o.first  = take && r0_v;
  assign push_o.second = take && r1_v;
  assign res0_o        = r0;
  assign res1_o        = r1;

  // Only the end-of-image word can follow another result of the same byte
  a_second_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.second |-> (res1_o.kind == KIND_DONE && res0_o.last_of_run == 1'b0))
    else $error("second result of a byte is not done");

  // Once halted, bytes without a restart give nothing
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !first_q && st_q.phase == PH_HALT) |-> !push_o.first)
    else $error("result produced while halted");

  // A consumed final byte always leaves the walker halted
  a_last_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_q) |=> st_q.phase == PH_HALT)
    else $error("final byte did not halt parsing");

endmodule

// ----- rtl/rwcp_res_queue.sv -----
// ----------------------------------------------------------------------------
// rwcp_res_queue
// Result queue: takes up to two results a cycle, hands out one a cycle while the output does not stall.
// ----------------------------------------------------------------------------
module rwcp_res_queue import rwcp_pkg::*; #(
  parameter int unsigned Depth = RWCP_RES_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  input  result_t   res0_i,
  input  result_t   res1_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output result_t   head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  result_t        mem_q [Depth];
  logic [AW-1:0]  wr_q, rd_q, wr_nx, wr_nx2, rd_nx;
  logic [CW-1:0]  cnt_q;
  logic           pop;
  logic [1:0]     push_n;

  function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign wr_nx  = bump(wr_q);
  assign wr_nx2 = bump(wr_nx);
  assign rd_nx  = bump(rd_q);
  assign pop    = out_valid_o && !out_stall_i;
  assign push_n = {1'b0, push_i.first} + {1'b0, push_i.second};

  assign room_o      = cnt_q <= CW'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.first)  mem_q[wr_q]  <= res0_i;
    if (push_i.second) mem_q[wr_nx] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.second)     wr_q <= wr_nx2;
      else if (push_i.first) wr_q <= wr_nx;
      if (pop) rd_q <= rd_nx;
      cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first |-> cnt_q <= CW'(Depth - 2))
    else $error("result pushed without room");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second |-> push_i.first)
    else $error("second result pushed alone");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.first) |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("queue count did not drop on pop");

endmodule

// ----- rtl/riff_wave_chunk_parser_top.sv -----
// Path: an accepted byte is held in the input register and parsed from there;
// its results are written to the result queue and offered from its head.
// Throughput: one byte per cycle while the result queue has room; a byte that
// causes two results hands them out one after the other through the single read port of the result queue.
// Reset: rst_ni is asynchronous; the parser restarts at the RIFF header and
// the input register and result queue come up empty.
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser_top
// Byte-wide RIFF WAVE chunk parser: header checks, PCM format report, data
// bytes and tagged INFO text bytes.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser_top import rwcp_pkg::*; #(
  parameter int unsigned ResDepth = RWCP_RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [1:0]  info_tag_o,
  output logic [15:0] channels_o,
  output logic [31:0] pcm_rate_o,
  output logic [15:0] sample_bits_o,
  output logic        last_of_run_o
);

  res_push_t push;
  result_t   res0, res1, head;
  logic      room;

  rwcp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .room_i       (room),
    .push_o       (push),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  rwcp_res_queue #(
    .Depth (ResDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o        = head.kind;
  assign byte_value_o  = head.byte_value;
  assign info_tag_o    = head.info_tag;
  assign channels_o    = head.channels;
  assign pcm_rate_o    = head.pcm_rate;
  assign sample_bits_o = head.sample_bits;
  assign last_of_run_o = head.last_of_run;

endmodule

// ----- test/riff_wave_chunk_parser_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser_top_test
// Feeds RIFF WAVE images to the parser one byte word at a time. A few hand
// built images come first, then random images that are mostly well formed,
// some corrupted, cut short or left open, plus noise. The expected results
// are worked out per accepted byte and checked in order against the output.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser_top_test import rwcp_pkg::*; ();

  typedef struct {
    logic [7:0] value;
    logic       first;
    logic       last;
    logic       wait_idle;
  } image_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  kind_o;
  logic [7:0]  byte_value_o;
  logic [1:0]  info_tag_o;
  logic [15:0] channels_o;
  logic [31:0] pcm_rate_o;
  logic [15:0] sample_bits_o;
  logic        last_of_run_o;

  image_word_t image_words_q[$];
  logic [7:0]  image_bytes[$];
  result_t     parsed_results_q[$];

  int mismatch_count = 0;
  int structured_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_cycle = 0;
  int stall_mode = 0;

  // Parser state as the stream should leave it
  phase_e      pr_phase;
  logic [3:0]  pr_index;
  logic [31:0] pr_id;
  logic [31:0] pr_size;
  logic [31:0] pr_chunk_left;
  logic [31:0] pr_list_left;
  logic [15:0] pr_code;
  logic [15:0] pr_channels;
  logic [31:0] pr_rate;
  logic [15:0] pr_bits;
  tag_e        pr_tag;

  riff_wave_chunk_parser_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .byte_value_o  (byte_value_o),
    .info_tag_o    (info_tag_o),
    .channels_o    (channels_o),
    .pcm_rate_o    (pcm_rate_o),
    .sample_bits_o (sample_bits_o),
    .last_of_run_o (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic clear_parse_state();
    pr_phase      = PH_RIFF;
    pr_index      = 4'd0;
    pr_id         = 32'd0;
    pr_size       = 32'd0;
    pr_chunk_left = 32'd0;
    pr_list_left  = 32'd0;
    pr_code       = 16'd0;
    pr_channels   = 16'd0;
    pr_rate       = 32'd0;
    pr_bits       = 16'd0;
    pr_tag        = TAG_NONE;
  endtask

  function automatic result_t wave_result(kind_e k, logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = k;
    if (k == KIND_PAYLOAD || k == KIND_INFO) r.byte_value = b;
    if (k == KIND_INFO) r.info_tag = pr_tag[1:0];
    if (k == KIND_FORMAT) begin
      r.channels    = pr_channels;
      r.pcm_rate    = pr_rate;
      r.sample_bits = pr_bits;
    end
    return r;
  endfunction

  // Advance the expected parser state by one byte and queue what it yields
  task automatic parse_wave_byte(input logic [7:0] b, input logic first, input logic last);
    result_t     found[$];
    result_t     tail;
    logic [3:0]  idx;
    logic [31:0] sz;
    if (first) clear_parse_state();
    idx = pr_index;
    case (pr_phase)
      PH_RIFF: begin
        if (idx >= 4'd4 && idx < 4'd8) pr_size = {b, pr_size[31:8]};
        else pr_id = {b, pr_id[31:8]};
        pr_index = idx + 4'd1;
        if (idx == 4'd3 && pr_id != ID_RIFF) begin
          found.push_back(wave_result(KIND_NOT_RIFF, 8'd0));
          pr_phase = PH_HALT;
        end else if (idx == 4'd11) begin
          if (pr_id != ID_WAVE) begin
            found.push_back(wave_result(KIND_NOT_WAVE, 8'd0));
            pr_phase = PH_HALT;
          end else begin
            pr_phase = PH_CHDR;
            pr_index = 4'd0;
          end
        end else if (last) begin
          found.push_back(wave_result(idx < 4'd3 ? KIND_NOT_RIFF : KIND_NOT_WAVE, 8'd0));
          pr_phase = PH_HALT;
        end
      end
      PH_CHDR: begin
        if (idx < 4'd4) pr_id = {b, pr_id[31:8]};
        else pr_size = {b, pr_size[31:8]};
        pr_index = idx + 4'd1;
        if (idx >= 4'd7) begin
          sz = pr_size[31] ? 32'd0 : pr_size;
          pr_index = 4'd0;
          if (pr_id == ID_FMT) begin
            if (sz < FMT_MIN_SIZE) begin
              found.push_back(wave_result(KIND_SHORT_FMT, 8'd0));
              pr_phase = PH_HALT;
            end else begin
              pr_chunk_left = sz - FMT_MIN_SIZE;
              pr_phase = PH_FMT;
            end
          end else if (pr_id == ID_LIST) begin
            pr_list_left = (sz >= LIST_TYPE_SIZE) ? sz - LIST_TYPE_SIZE : 32'd0;
            pr_phase = PH_LTYP;
          end else begin
            pr_chunk_left = sz;
            if (sz == 32'd0) pr_phase = PH_CHDR;
            else if (pr_id == ID_DATA) pr_phase = PH_DATA;
            else pr_phase = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        case (idx)
          4'd0: pr_code = {8'd0, b};
          4'd1: pr_code[15:8] = b;
          4'd2: pr_channels = {8'd0, b};
          4'd3: pr_channels[15:8] = b;
          4'd4: pr_rate = {24'd0, b};
          4'd5: pr_rate[15:8] = b;
          4'd6: pr_rate[23:16] = b;
          4'd7: pr_rate[31:24] = b;
          4'd14: pr_bits = {8'd0, b};
          4'd15: pr_bits[15:8] = b;
          default: ;
        endcase
        pr_index = idx + 4'd1;
        if (idx == 4'd1 && pr_code != FMT_CODE_PCM) begin
          found.push_back(wave_result(KIND_NOT_PCM, 8'd0));
          pr_phase = PH_HALT;
        end else if (idx == 4'd15) begin
          found.push_back(wave_result(KIND_FORMAT, 8'd0));
          pr_index = 4'd0;
          pr_phase = (pr_chunk_left != 32'd0) ? PH_SKIP : PH_CHDR;
        end
      end
      PH_DATA, PH_SKIP: begin
        if (pr_phase == PH_DATA) found.push_back(wave_result(KIND_PAYLOAD, b));
        if (pr_chunk_left != 32'd0) pr_chunk_left--;
        if (pr_chunk_left == 32'd0) begin
          pr_phase = PH_CHDR;
          pr_index = 4'd0;
        end
      end
      PH_LTYP: begin
        pr_id = {b, pr_id[31:8]};
        pr_index = idx + 4'd1;
        if (idx >= 4'd3) begin
          pr_index = 4'd0;
          if (pr_list_left == 32'd0) begin
            pr_phase = PH_CHDR;
          end else if (pr_id == ID_INFO) begin
            pr_phase = PH_IHDR;
          end else begin
            pr_chunk_left = pr_list_left;
            pr_phase = PH_SKIP;
          end
        end
      end
      PH_IHDR: begin
        if (idx < 4'd4) pr_id = {b, pr_id[31:8]};
        else pr_size = {b, pr_size[31:8]};
        pr_index = idx + 4'd1;
        if (pr_list_left != 32'd0) pr_list_left--;
        if (idx >= 4'd7) begin
          pr_index = 4'd0;
          sz = pr_size[31] ? 32'd0 : pr_size;
          if (pr_id == ID_IART) pr_tag = TAG_ARTIST;
          else if (pr_id == ID_ICOP) pr_tag = TAG_COPYRIGHT;
          else if (pr_id == ID_ICRD) pr_tag = TAG_DATE;
          else if (pr_id == ID_INAM) pr_tag = TAG_NAME;
          else pr_tag = TAG_NONE;
          pr_chunk_left = sz;
          pr_phase = (sz != 32'd0) ? PH_IBODY : PH_IHDR;
        end
        // LIST used up: fall back to top-level chunk headers
        if (pr_list_left == 32'd0) begin
          pr_phase = PH_CHDR;
          pr_index = 4'd0;
        end
      end
      PH_IBODY: begin
        if (pr_tag != TAG_NONE) found.push_back(wave_result(KIND_INFO, b));
        if (pr_list_left != 32'd0) pr_list_left--;
        if (pr_chunk_left != 32'd0) pr_chunk_left--;
        if (pr_chunk_left == 32'd0) begin
          pr_phase = PH_IHDR;
          pr_index = 4'd0;
        end
        if (pr_list_left == 32'd0) begin
          pr_phase = PH_CHDR;
          pr_index = 4'd0;
        end
      end
      default: ;
    endcase
    if (last && pr_phase != PH_HALT) begin
      found.push_back(wave_result(KIND_DONE, 8'd0));
      pr_phase = PH_HALT;
    end
    if (found.size() != 0) begin
      tail = found.pop_back();
      tail.last_of_run = 1'b1;
      found.push_back(tail);
    end
    foreach (found[i]) parsed_results_q.push_back(found[i]);
  endtask

  task automatic put8(input logic [7:0] b);
    image_bytes.push_back(b);
  endtask

  task automatic put16(input logic [15:0] h);
    put8(h[7:0]);
    put8(h[15:8]);
  endtask

  task automatic put32(input logic [31:0] w);
    put16(w[15:0]);
    put16(w[31:16]);
  endtask

  task automatic add_riff_header(input logic [31:0] id, input logic [31:0] form);
    put32(id);
    put32($urandom);
    put32(form);
  endtask

  // Move the assembled image into the send queue
  task automatic ship_image(input logic mark_first, input logic mark_last,
                            input logic wait_idle);
    image_word_t w;
    for (int i = 0; i < image_bytes.size(); i++) begin
      w.value     = image_bytes[i];
      w.first     = mark_first && (i == 0);
      w.last      = mark_last && (i == image_bytes.size() - 1);
      w.wait_idle = wait_idle && (i == 0);
      image_words_q.push_back(w);
    end
    image_bytes.delete();
  endtask

  task automatic add_fmt_chunk();
    logic [31:0] size;
    int          extra;
    extra = 0;
    case ($urandom_range(0, 9))
      0: size = $urandom_range(0, 15);
      1: size = 32'h8000_0000 | $urandom;
      2: begin
        extra = $urandom_range(1, 6);
        size = FMT_MIN_SIZE + extra;
      end
      default: size = FMT_MIN_SIZE;
    endcase
    put32(ID_FMT);
    put32(size);
    put16($urandom_range(0, 7) == 0 ? 16'($urandom) : FMT_CODE_PCM);
    put16(16'($urandom));
    put32($urandom);
    put32($urandom);
    put16(16'($urandom));
    put16(16'($urandom));
    repeat (extra) put8(8'($urandom));
  endtask

  task automatic add_data_chunk();
    logic [31:0] size;
    int          count;
    count = $urandom_range(0, 12);
    case ($urandom_range(0, 9))
      0: size = 32'h8000_0000 | $urandom;
      1: size = $urandom_range(1000, 32'h7FFF_FFFF);
      default: size = count;
    endcase
    put32(ID_DATA);
    put32(size);
    repeat (count) put8(8'($urandom));
  endtask

  task automatic add_other_chunk();
    int count;
    count = $urandom_range(0, 8);
    put32($urandom);
    put32(count);
    repeat (count) put8(8'($urandom));
  endtask

  task automatic add_list_chunk();
    logic [31:0] ids[4];
    int          sizes[4];
    int          count;
    int          total;
    logic [31:0] list_size;
    count = $urandom_range(0, 3);
    total = 4;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: ids[i] = ID_IART;
        1: ids[i] = ID_ICOP;
        2: ids[i] = ID_ICRD;
        3: ids[i] = ID_INAM;
        default: ids[i] = $urandom;
      endcase
      sizes[i] = $urandom_range(0, 6);
      total += 8 + sizes[i];
    end
    list_size = total;
    // Now and then make the LIST disagree with its contents
    case ($urandom_range(0, 9))
      0: list_size = $urandom_range(0, 7);
      1: list_size = 32'h8000_0000 | $urandom;
      2: list_size = total - $urandom_range(1, 4);
      default: ;
    endcase
    put32(ID_LIST);
    put32(list_size);
    put32($urandom_range(0, 4) == 0 ? $urandom : ID_INFO);
    for (int i = 0; i < count; i++) begin
      put32(ids[i]);
      put32($urandom_range(0, 9) == 0 ? 32'h8000_0000 | $urandom : sizes[i]);
      repeat (sizes[i]) put8(8'($urandom));
    end
  endtask

  task automatic add_random_image(input int serial);
    int pick;
    int chunks;
    int cut;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) put8(8'($urandom));
      ship_image(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      return;
    end
    pick = $urandom_range(0, 14);
    add_riff_header(pick == 0 ? ID_RIFF ^ (32'd1 << $urandom_range(0, 31)) : ID_RIFF,
                    pick == 1 ? ID_WAVE ^ (32'd1 << $urandom_range(0, 31)) : ID_WAVE);
    chunks = $urandom_range(1, 5);
    for (int i = 0; i < chunks; i++) begin
      pick = (i == 0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 9);
      if (pick <= 1) add_fmt_chunk();
      else if (pick <= 4) add_data_chunk();
      else if (pick <= 7) add_list_chunk();
      else add_other_chunk();
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      cut = $urandom_range(1, image_bytes.size());
      while (image_bytes.size() > cut) void'(image_bytes.pop_back());
    end
    structured_count += image_bytes.size();
    ship_image($urandom_range(0, 19) != 0, pick != 1, serial % 8 == 3);
  endtask

  // Byte sender: bursts and gaps, never drops valid while stalled
  always @(posedge clk_i) begin
    image_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) parse_wave_byte(data_byte_i, first_byte_i, last_byte_i);
      if (in_valid_i && in_stall_o) begin
        // hold the word
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (image_words_q.size() == 0 ||
                   (image_words_q[0].wait_idle && parsed_results_q.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        w = image_words_q.pop_front();
        in_valid_i   <= 1'b1;
        data_byte_i  <= w.value;
        first_byte_i <= w.first;
        last_byte_i  <= w.last;
        if (burst_left != 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(50, 300);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = $urandom_range(0, 6);
        end
      end
    end
  end

  // Result checker and output stall pattern
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen.kind        = kind_e'(kind_o);
        seen.byte_value  = byte_value_o;
        seen.info_tag    = info_tag_o;
        seen.channels    = channels_o;
        seen.pcm_rate    = pcm_rate_o;
        seen.sample_bits = sample_bits_o;
        seen.last_of_run = last_of_run_o;
        if (parsed_results_q.size() == 0) begin
          $display("%0t: expected no result, got kind %0d byte %02h last %0b",
                   $time, kind_o, byte_value_o, last_of_run_o);
          mismatch_count++;
        end else begin
          want = parsed_results_q.pop_front();
          if (seen !== want) begin
            $display({"%0t: expected kind %0d byte %02h tag %0d ch %0d rate %0d bits %0d",
                      " last %0b, got kind %0d byte %02h tag %0d ch %0d rate %0d bits %0d",
                      " last %0b"}, $time,
                     want.kind, want.byte_value, want.info_tag, want.channels,
                     want.pcm_rate, want.sample_bits, want.last_of_run,
                     kind_o, byte_value_o, info_tag_o, channels_o,
                     pcm_rate_o, sample_bits_o, last_of_run_o);
            mismatch_count++;
          end
        end
      end
      stall_cycle++;
      if (stall_cycle % 160 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= (stall_cycle % 5 != 0);
        default: out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  initial begin
    int serial;
    clear_parse_state();

    // Image ends inside the RIFF identifier
    put8(ID_RIFF[7:0]);
    put8(ID_RIFF[15:8]);
    ship_image(1'b1, 1'b1, 1'b0);
    // Image ends inside the RIFF size
    put32(ID_RIFF);
    put16(16'hFFFF);
    ship_image(1'b1, 1'b1, 1'b0);
    // Complete image: extreme fmt fields, payload, one artist byte, done on the last
    add_riff_header(ID_RIFF, ID_WAVE);
    put32(ID_FMT);
    put32(FMT_MIN_SIZE);
    put16(FMT_CODE_PCM);
    put16(16'hFFFF);
    put32(32'hFFFF_FFFF);
    put32(32'd0);
    put16(16'd0);
    put16(16'd0);
    put32(ID_DATA);
    put32(32'd2);
    put8(8'h00);
    put8(8'hFF);
    put32(ID_LIST);
    put32(32'd13);
    put32(ID_INFO);
    put32(ID_IART);
    put32(32'd1);
    put8(8'h41);
    ship_image(1'b1, 1'b1, 1'b1);
    // Short fmt chunk
    add_riff_header(ID_RIFF, ID_WAVE);
    put32(ID_FMT);
    put32(32'd8);
    ship_image(1'b1, 1'b1, 1'b0);
    // Format code other than PCM
    add_riff_header(ID_RIFF, ID_WAVE);
    put32(ID_FMT);
    put32(FMT_MIN_SIZE);
    put16(16'd3);
    ship_image(1'b1, 1'b0, 1'b0);

    serial = 0;
    while (structured_count < 1900) begin
      add_random_image(serial);
      serial++;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (image_words_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (parsed_results_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("riff_wave_chunk_parser_top_test passed");
    else
      $display("riff_wave_chunk_parser_top_test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("riff_wave_chunk_parser_top_test failed");
    $finish;
  end

endmodule
